[rtl/core/dcc_pkg.sv]
package dcc_pkg;

  localparam int CHANNEL_BITS   = 8;
  localparam int MARGIN_BITS    = 8;
  localparam int SCALE_BITS     = 10;
  localparam int SHARE_BITS     = 10;
  localparam int OUT_IMAGE_BITS = 16;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 10;
  localparam int NUM_CLASSES    = 3;
  localparam int DIV_STEP_BITS  = $clog2(SHARE_BITS);

  localparam int DEF_PIXEL_COUNT_BITS = 22;
  localparam int DEF_IMAGE_COUNT_BITS = 16;
  localparam int DEF_QUEUE_DEPTH      = 4;

  localparam logic [MARGIN_BITS-1:0] MARGIN_RESET = MARGIN_BITS'(100);
  localparam logic [SCALE_BITS-1:0]  SCALE_RESET  = SCALE_BITS'(200);

  // Configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_MARGIN = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_SCALE  = CFG_INDEX_BITS'(1);

  typedef enum logic [1:0] {
    CLS_BLUE  = 2'd0,
    CLS_GREEN = 2'd1,
    CLS_RED   = 2'd2
  } class_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MULT,
    BK_DIVIDE,
    BK_RESULT
  } back_state_t;

  // Channel a beats both b and c by at least the margin.
  function automatic logic dominates(
    input logic [CHANNEL_BITS-1:0] a,
    input logic [CHANNEL_BITS-1:0] b,
    input logic [CHANNEL_BITS-1:0] c,
    input logic [MARGIN_BITS-1:0]  m
  );
    logic [CHANNEL_BITS:0] a_ext;
    logic [CHANNEL_BITS:0] b_lim;
    logic [CHANNEL_BITS:0] c_lim;
    a_ext = {1'b0, a};
    b_lim = {1'b0, b} + {1'b0, m};
    c_lim = {1'b0, c} + {1'b0, m};
    return (a_ext >= b_lim) && (a_ext >= c_lim);
  endfunction

endpackage

[rtl/core/dcc_if.sv]
interface dcc_pixel_if import dcc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CHANNEL_BITS-1:0] red;
  logic [CHANNEL_BITS-1:0] green;
  logic [CHANNEL_BITS-1:0] blue;
  logic                    last_of_image;
  logic                    new_bank;

  modport source (output valid, red, green, blue, last_of_image, new_bank, input ready);
  modport sink   (input valid, red, green, blue, last_of_image, new_bank, output ready);
endinterface

interface dcc_result_if import dcc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [1:0]                dominant;
  logic [SHARE_BITS-1:0]     blue_share;
  logic [SHARE_BITS-1:0]     green_share;
  logic [SHARE_BITS-1:0]     red_share;
  logic [OUT_IMAGE_BITS-1:0] blue_images;
  logic [OUT_IMAGE_BITS-1:0] green_images;
  logic [OUT_IMAGE_BITS-1:0] red_images;

  modport source (output valid, dominant, blue_share, green_share, red_share,
                  blue_images, green_images, red_images, input ready);
  modport sink   (input valid, dominant, blue_share, green_share, red_share,
                  blue_images, green_images, red_images, output ready);
endinterface

interface dcc_cfg_if import dcc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [CFG_DATA_BITS-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/dcc_front.sv]
module dcc_front import dcc_pkg::*; #(
  parameter int PIXEL_COUNT_BITS = DEF_PIXEL_COUNT_BITS,
  parameter int ENTRY_BITS       = 4 * DEF_PIXEL_COUNT_BITS + 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [MARGIN_BITS-1:0] margin,
  dcc_pixel_if.sink              pixel,
  input  logic                   enq_full,
  output logic                   enq_valid,
  output logic [ENTRY_BITS-1:0]  enq_data
);

  localparam int P = PIXEL_COUNT_BITS;

  logic [P-1:0] cnt [NUM_CLASSES];
  logic [P-1:0] total;
  logic         clear_pending;

  logic [P-1:0]           cnt_inc [NUM_CLASSES];
  logic [P-1:0]           total_inc;
  logic [NUM_CLASSES-1:0] hit;
  logic                   accept;

  assign pixel.ready = !enq_full;
  assign accept      = pixel.valid && pixel.ready;

  always_comb begin
    hit = '0;
    priority if (dominates(pixel.blue, pixel.green, pixel.red, margin)) begin
      hit[CLS_BLUE] = 1'b1;
    end else if (dominates(pixel.green, pixel.blue, pixel.red, margin)) begin
      hit[CLS_GREEN] = 1'b1;
    end else if (dominates(pixel.red, pixel.green, pixel.blue, margin)) begin
      hit[CLS_RED] = 1'b1;
    end else begin
      hit = '0;
    end
  end

  always_comb begin
    total_inc = (total == '1) ? total : total + 1'b1;
    for (int k = 0; k < NUM_CLASSES; k++) begin
      cnt_inc[k] = (hit[k] && cnt[k] != '1) ? cnt[k] + 1'b1 : cnt[k];
    end
  end

  // Hand the finished image to the back end; bank clear rides along with it.
  assign enq_valid = accept && pixel.last_of_image;
  assign enq_data  = {clear_pending | pixel.new_bank, total_inc,
                      cnt_inc[CLS_RED], cnt_inc[CLS_GREEN], cnt_inc[CLS_BLUE]};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_CLASSES; k++) begin
        cnt[k] <= '0;
      end
      total         <= '0;
      clear_pending <= 1'b0;
    end else if (accept) begin
      if (pixel.last_of_image) begin
        for (int k = 0; k < NUM_CLASSES; k++) begin
          cnt[k] <= '0;
        end
        total         <= '0;
        clear_pending <= 1'b0;
      end else begin
        for (int k = 0; k < NUM_CLASSES; k++) begin
          cnt[k] <= cnt_inc[k];
        end
        total         <= total_inc;
        clear_pending <= clear_pending | pixel.new_bank;
      end
    end
  end

endmodule

[rtl/core/dcc_queue.sv]
module dcc_queue import dcc_pkg::*; #(
  parameter int WIDTH = 4 * DEF_PIXEL_COUNT_BITS + 1,
  parameter int DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] head
);

  localparam int PTR_BITS = $clog2(DEPTH);
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    slots [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;

  assign full      = (count == CNT_BITS'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/core/dcc_back.sv]
module dcc_back import dcc_pkg::*; #(
  parameter int PIXEL_COUNT_BITS = DEF_PIXEL_COUNT_BITS,
  parameter int IMAGE_COUNT_BITS = DEF_IMAGE_COUNT_BITS,
  parameter int ENTRY_BITS       = 4 * DEF_PIXEL_COUNT_BITS + 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [SCALE_BITS-1:0] scale,
  input  logic                  job_valid,
  input  logic [ENTRY_BITS-1:0] job_data,
  output logic                  job_pop,
  dcc_result_if.source          result
);

  localparam int P  = PIXEL_COUNT_BITS;
  localparam int I  = IMAGE_COUNT_BITS;
  localparam int NW = P + SCALE_BITS;

  back_state_t state;
  back_state_t state_next;

  logic [P-1:0]              job_cnt  [NUM_CLASSES];
  logic                      job_clear;
  logic [NW-1:0]             rem      [NUM_CLASSES];
  logic [SHARE_BITS-1:0]     quo      [NUM_CLASSES];
  logic [NW-1:0]             dsh;
  logic [DIV_STEP_BITS-1:0]  step;
  logic [I-1:0]              totals   [NUM_CLASSES];

  logic                      res_valid;
  class_t                    res_dom;
  logic [SHARE_BITS-1:0]     res_share  [NUM_CLASSES];
  logic [OUT_IMAGE_BITS-1:0] res_images [NUM_CLASSES];

  logic   load_job;
  logic   start_div;
  logic   div_step;
  logic   load_result;
  logic   out_free;
  class_t win;
  logic [I-1:0] totals_new [NUM_CLASSES];

  assign out_free = !res_valid || result.ready;

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE:   if (job_valid) state_next = BK_MULT;
      BK_MULT:   state_next = BK_DIVIDE;
      BK_DIVIDE: if (step == '0) state_next = BK_RESULT;
      BK_RESULT: if (out_free) state_next = BK_IDLE;
      default:   state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    load_job    = 1'b0;
    start_div   = 1'b0;
    div_step    = 1'b0;
    load_result = 1'b0;
    unique case (state)
      BK_IDLE:   load_job    = job_valid;
      BK_MULT:   start_div   = 1'b1;
      BK_DIVIDE: div_step    = 1'b1;
      BK_RESULT: load_result = out_free;
      default:   load_job    = 1'b0;
    endcase
  end

  assign job_pop = load_job;

  // Argmax over the truncated shares; ties go blue, then green, then red.
  always_comb begin
    if (quo[CLS_BLUE] >= quo[CLS_GREEN] && quo[CLS_BLUE] >= quo[CLS_RED]) begin
      win = CLS_BLUE;
    end else if (quo[CLS_GREEN] >= quo[CLS_RED]) begin
      win = CLS_GREEN;
    end else begin
      win = CLS_RED;
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_CLASSES; k++) begin
      totals_new[k] = job_clear ? '0 : totals[k];
      if (k == int'(win) && totals_new[k] != '1) begin
        totals_new[k] = totals_new[k] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load_job) begin
      for (int k = 0; k < NUM_CLASSES; k++) begin
        job_cnt[k] <= job_data[k*P +: P];
      end
      dsh       <= NW'(job_data[NUM_CLASSES*P +: P]) << (SHARE_BITS - 1);
      job_clear <= job_data[(NUM_CLASSES+1)*P];
    end
    if (start_div) begin
      for (int k = 0; k < NUM_CLASSES; k++) begin
        rem[k] <= NW'(job_cnt[k]) * NW'(scale);
        quo[k] <= '0;
      end
      step <= DIV_STEP_BITS'(SHARE_BITS - 1);
    end
    // Restoring division, one quotient bit per cycle for all three classes.
    if (div_step) begin
      for (int k = 0; k < NUM_CLASSES; k++) begin
        if (rem[k] >= dsh) begin
          rem[k] <= rem[k] - dsh;
          quo[k] <= {quo[k][SHARE_BITS-2:0], 1'b1};
        end else begin
          quo[k] <= {quo[k][SHARE_BITS-2:0], 1'b0};
        end
      end
      dsh  <= dsh >> 1;
      step <= step - 1'b1;
    end
    if (load_result) begin
      res_dom <= win;
      for (int k = 0; k < NUM_CLASSES; k++) begin
        res_share[k]  <= quo[k];
        res_images[k] <= OUT_IMAGE_BITS'(totals_new[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      for (int k = 0; k < NUM_CLASSES; k++) begin
        totals[k] <= '0;
      end
    end else begin
      if (load_result) begin
        res_valid <= 1'b1;
        for (int k = 0; k < NUM_CLASSES; k++) begin
          totals[k] <= totals_new[k];
        end
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  assign result.valid        = res_valid;
  assign result.dominant     = res_dom;
  assign result.blue_share   = res_share[CLS_BLUE];
  assign result.green_share  = res_share[CLS_GREEN];
  assign result.red_share    = res_share[CLS_RED];
  assign result.blue_images  = res_images[CLS_BLUE];
  assign result.green_images = res_images[CLS_GREEN];
  assign result.red_images   = res_images[CLS_RED];

endmodule

[rtl/core/dominant_color_classifier.sv]
// Dominant color classifier.
// pixel channel: one RGB pixel per transfer, with last_of_image marking the
//   end of an image and new_bank clearing the per-class image totals.
// result channel: one transfer per image, after its last pixel, carrying the
//   winning class, the three scaled shares and the three image totals.
// cfg channel: register writes (index 0 margin, index 1 share scale), always
//   ready; write only while no image is in flight.
// Pixels are taken one per cycle while the image queue is not full. Each image
//   ends in a back-end job (dequeue, multiply, ten restoring-division steps,
//   result); the back end runs one job at a time, so it takes the next image
//   from the queue only after loading the result of the last one.
// A queue of QUEUE_DEPTH finished images sits between pixel counting and the
//   divider; pixel ready drops only when that queue is full.
// A stalled result holds in the output register; the divider keeps working
//   on the next image and waits only when it has another result to deliver.
// Reset clears all counters and totals and loads margin 100 and scale 200.
module dominant_color_classifier import dcc_pkg::*; #(
  parameter int PIXEL_COUNT_BITS = DEF_PIXEL_COUNT_BITS,
  parameter int IMAGE_COUNT_BITS = DEF_IMAGE_COUNT_BITS,
  parameter int QUEUE_DEPTH      = DEF_QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  dcc_pixel_if.sink    pixel,
  dcc_result_if.source result,
  dcc_cfg_if.sink      cfg
);

  localparam int ENTRY_BITS = 4 * PIXEL_COUNT_BITS + 1;

  logic [MARGIN_BITS-1:0] margin;
  logic [SCALE_BITS-1:0]  scale;

  logic                  enq_valid;
  logic [ENTRY_BITS-1:0] enq_data;
  logic                  q_full;
  logic                  q_not_empty;
  logic                  q_pop;
  logic [ENTRY_BITS-1:0] q_head;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      margin <= MARGIN_RESET;
      scale  <= SCALE_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_MARGIN: margin <= cfg.data[MARGIN_BITS-1:0];
        REG_SCALE:  scale  <= cfg.data[SCALE_BITS-1:0];
        default:    ;
      endcase
    end
  end

  dcc_front #(
    .PIXEL_COUNT_BITS (PIXEL_COUNT_BITS),
    .ENTRY_BITS       (ENTRY_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .margin    (margin),
    .pixel     (pixel),
    .enq_full  (q_full),
    .enq_valid (enq_valid),
    .enq_data  (enq_data)
  );

  dcc_queue #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (enq_valid),
    .push_data (enq_data),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  dcc_back #(
    .PIXEL_COUNT_BITS (PIXEL_COUNT_BITS),
    .IMAGE_COUNT_BITS (IMAGE_COUNT_BITS),
    .ENTRY_BITS       (ENTRY_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .scale     (scale),
    .job_valid (q_not_empty),
    .job_data  (q_head),
    .job_pop   (q_pop),
    .result    (result)
  );

endmodule

[bench/dominant_color_classifier_test.sv]
module dominant_color_classifier_test;
  import dcc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIX_BITS       = DEF_PIXEL_COUNT_BITS;
  localparam int IMG_BITS       = DEF_IMAGE_COUNT_BITS;
  localparam int SETTLE_CYCLES  = 24;
  localparam int LIMIT_CYCLES   = 500000;
  localparam int RANDOM_PIXELS  = 320;
  localparam int NOISE          = NUM_CLASSES;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] red;
    logic [CHANNEL_BITS-1:0] green;
    logic [CHANNEL_BITS-1:0] blue;
    logic                    last_of_image;
    logic                    new_bank;
  } pixel_t;

  typedef struct packed {
    class_t                                       dominant;
    logic [NUM_CLASSES-1:0][SHARE_BITS-1:0]       share;
    logic [NUM_CLASSES-1:0][OUT_IMAGE_BITS-1:0]   tally;
  } verdict_t;

  logic clk = 1'b0;
  logic rst;

  dcc_pixel_if  pixel_bus ();
  dcc_result_if result_bus ();
  dcc_cfg_if    cfg_bus ();

  dominant_color_classifier DUT (
    .clk    (clk),
    .rst    (rst),
    .pixel  (pixel_bus),
    .result (result_bus),
    .cfg    (cfg_bus)
  );

  always #4 clk = ~clk;

  // Classifier state as the block should hold it
  logic [MARGIN_BITS-1:0] margin_q;
  logic [SCALE_BITS-1:0]  scale_q;
  logic [PIX_BITS-1:0]    class_pixels [NUM_CLASSES];
  logic [PIX_BITS-1:0]    image_pixels;
  logic [IMG_BITS-1:0]    image_tally  [NUM_CLASSES];
  verdict_t               verdicts_due [$];

  int  mismatches   = 0;
  int  items_sent   = 0;
  int  images_sent  = 0;
  int  results_seen = 0;
  int  cycle_count  = 0;
  int  hold_off     = 0;
  int  stall_left   = 0;
  bit  no_idle      = 1'b0;

  function automatic logic [31:0] bump(logic [31:0] v, logic [31:0] top);
    return (v >= top) ? top : v + 1;
  endfunction

  function automatic bit beats(logic [7:0] a, logic [7:0] b, logic [7:0] c);
    return (int'(a) - int'(b) >= int'(margin_q)) && (int'(a) - int'(c) >= int'(margin_q));
  endfunction

  function automatic void account_pixel(pixel_t p);
    logic [63:0] share [NUM_CLASSES];
    class_t      winner;
    verdict_t    v;
    if (p.new_bank) begin
      foreach (image_tally[k]) image_tally[k] = '0;
    end
    image_pixels = PIX_BITS'(bump(image_pixels, (1 << PIX_BITS) - 1));
    if (beats(p.blue, p.green, p.red))
      class_pixels[CLS_BLUE] = PIX_BITS'(bump(class_pixels[CLS_BLUE], (1 << PIX_BITS) - 1));
    else if (beats(p.green, p.blue, p.red))
      class_pixels[CLS_GREEN] = PIX_BITS'(bump(class_pixels[CLS_GREEN], (1 << PIX_BITS) - 1));
    else if (beats(p.red, p.green, p.blue))
      class_pixels[CLS_RED] = PIX_BITS'(bump(class_pixels[CLS_RED], (1 << PIX_BITS) - 1));
    if (!p.last_of_image) return;

    foreach (share[k]) share[k] = (64'(class_pixels[k]) * 64'(scale_q)) / 64'(image_pixels);
    if (share[CLS_BLUE] >= share[CLS_GREEN] && share[CLS_BLUE] >= share[CLS_RED])
      winner = CLS_BLUE;
    else if (share[CLS_GREEN] >= share[CLS_RED])
      winner = CLS_GREEN;
    else
      winner = CLS_RED;
    image_tally[winner] = IMG_BITS'(bump(image_tally[winner], (1 << IMG_BITS) - 1));

    v.dominant = winner;
    for (int k = 0; k < NUM_CLASSES; k++) begin
      v.share[k] = share[k][SHARE_BITS-1:0];
      v.tally[k] = OUT_IMAGE_BITS'(image_tally[k]);
    end
    verdicts_due.push_back(v);
    images_sent++;
    foreach (class_pixels[k]) class_pixels[k] = '0;
    image_pixels = '0;
  endfunction

  // Mostly back-to-back, sometimes a short gap, rarely a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Lean toward one class, each other channel near the margin threshold or below it
  function automatic pixel_t random_pixel(int lean);
    pixel_t p;
    int     hi;
    int     lo;
    int     other [2];
    p.red           = 8'($urandom_range(0, 255));
    p.green         = 8'($urandom_range(0, 255));
    p.blue          = 8'($urandom_range(0, 255));
    p.last_of_image = 1'b0;
    p.new_bank      = ($urandom_range(0, 19) == 0);
    if (lean < NUM_CLASSES && $urandom_range(0, 3) != 0) begin
      hi = $urandom_range(int'(margin_q), 255);
      lo = hi - int'(margin_q);
      foreach (other[k]) begin
        if ($urandom_range(0, 1) == 1) begin
          other[k] = lo + int'($urandom_range(0, 4)) - 2;
          other[k] = (other[k] < 0) ? 0 : (other[k] > 255) ? 255 : other[k];
        end else begin
          other[k] = $urandom_range(0, lo);
        end
      end
      case (lean)
        CLS_BLUE:  begin p.blue  = 8'(hi); p.green = 8'(other[0]); p.red   = 8'(other[1]); end
        CLS_GREEN: begin p.green = 8'(hi); p.blue  = 8'(other[0]); p.red   = 8'(other[1]); end
        default:   begin p.red   = 8'(hi); p.green = 8'(other[0]); p.blue  = 8'(other[1]); end
      endcase
    end
    return p;
  endfunction

  function automatic pixel_t make_pixel(int r, int g, int b, bit last, bit bank);
    pixel_t p;
    p.red           = 8'(r);
    p.green         = 8'(g);
    p.blue          = 8'(b);
    p.last_of_image = last;
    p.new_bank      = bank;
    return p;
  endfunction

  task automatic send_pixel(pixel_t p);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      pixel_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pixel_bus.valid         <= 1'b1;
    pixel_bus.red           <= p.red;
    pixel_bus.green         <= p.green;
    pixel_bus.blue          <= p.blue;
    pixel_bus.last_of_image <= p.last_of_image;
    pixel_bus.new_bank      <= p.new_bank;
    @(posedge clk);
    while (pixel_bus.ready !== 1'b1) @(posedge clk);
    account_pixel(p);
    items_sent++;
  endtask

  task automatic send_image(int len, int lean);
    pixel_t p;
    for (int k = 0; k < len; k++) begin
      p = random_pixel(lean);
      p.last_of_image = (k == len - 1);
      send_pixel(p);
    end
  endtask

  // Drop valid, drain all results, then let the back end settle
  task automatic wait_idle();
    pixel_bus.valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] word);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= word;
    @(posedge clk);
    while (cfg_bus.ready !== 1'b1) @(posedge clk);
    if (idx == REG_MARGIN)
      margin_q = word[MARGIN_BITS-1:0];
    else if (idx == REG_SCALE)
      scale_q = word[SCALE_BITS-1:0];
  endtask

  task automatic configure(logic [CFG_DATA_BITS-1:0] margin_word,
                           logic [CFG_DATA_BITS-1:0] scale_word, bit spare = 1'b0);
    wait_idle();
    write_reg(REG_MARGIN, margin_word);
    write_reg(REG_SCALE, scale_word);
    // Unmapped indexes must leave both registers alone
    if (spare) begin
      for (int i = 0; i < (1 << CFG_INDEX_BITS); i++) begin
        if (i != REG_MARGIN && i != REG_SCALE)
          write_reg(CFG_INDEX_BITS'(i), CFG_DATA_BITS'($urandom));
      end
    end
    cfg_bus.valid <= 1'b0;
  endtask

  // Result side: random stalls, plus a long hold-off when a test asks
  initial begin
    result_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off > 0) begin
        result_bus.ready <= 1'b0;
        hold_off--;
      end else if (stall_left > 0) begin
        result_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        result_bus.ready <= 1'b1;
        if (!no_idle && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  task automatic compare(string what, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    verdict_t want;
    if (!rst && result_bus.valid === 1'b1 && result_bus.ready === 1'b1) begin
      results_seen++;
      if (verdicts_due.size() == 0) begin
        mismatches++;
        $display("%0t: result transfer with nothing expected", $time);
      end else begin
        want = verdicts_due.pop_front();
        compare("dominant",     want.dominant,        result_bus.dominant);
        compare("blue_share",   want.share[CLS_BLUE],  result_bus.blue_share);
        compare("green_share",  want.share[CLS_GREEN], result_bus.green_share);
        compare("red_share",    want.share[CLS_RED],   result_bus.red_share);
        compare("blue_images",  want.tally[CLS_BLUE],  result_bus.blue_images);
        compare("green_images", want.tally[CLS_GREEN], result_bus.green_images);
        compare("red_images",   want.tally[CLS_RED],   result_bus.red_images);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("%0t: timed out, %0d results outstanding", $time, verdicts_due.size());
      $display("** dominant_color_classifier: FAILED **");
      $finish;
    end
  end

  // Reset values: margin 100, scale 200
  task automatic test_reset_defaults();
    // blue pure, green exactly at margin, red one short: blue/green tie
    send_pixel(make_pixel(0, 0, 255, 1'b0, 1'b0));
    send_pixel(make_pixel(0, 100, 0, 1'b0, 1'b0));
    send_pixel(make_pixel(99, 0, 0, 1'b1, 1'b0));
    // bank clear on the last pixel, nothing classified
    send_pixel(make_pixel(255, 255, 255, 1'b1, 1'b1));
    send_pixel(make_pixel(200, 100, 100, 1'b0, 1'b0));
    send_pixel(make_pixel(255, 0, 0, 1'b1, 1'b0));
    send_pixel(make_pixel(0, 255, 155, 1'b0, 1'b0));
    send_pixel(make_pixel(0, 0, 0, 1'b1, 1'b0));
  endtask

  // Zero margin: equal channels go to the first class in blue, green, red order
  task automatic test_margin_zero();
    configure(10'h300, 10'h3FF);
    send_pixel(make_pixel(7, 7, 7, 1'b0, 1'b0));
    send_pixel(make_pixel(9, 9, 3, 1'b0, 1'b0));
    send_pixel(make_pixel(9, 3, 9, 1'b0, 1'b0));
    send_pixel(make_pixel(9, 3, 3, 1'b0, 1'b0));
    send_pixel(make_pixel(9, 3, 3, 1'b1, 1'b0));
    send_pixel(make_pixel(0, 0, 0, 1'b1, 1'b0));
  endtask

  task automatic test_scale_extremes();
    // zero scale: every share is zero, blue wins
    configure(10'd255, 10'd0, 1'b1);
    send_pixel(make_pixel(0, 0, 255, 1'b0, 1'b0));
    send_pixel(make_pixel(255, 0, 0, 1'b1, 1'b0));
    // scale one: shares truncate to zero and tie
    configure(10'd255, 10'd1);
    send_pixel(make_pixel(0, 255, 0, 1'b0, 1'b0));
    send_pixel(make_pixel(255, 0, 0, 1'b0, 1'b0));
    send_pixel(make_pixel(255, 0, 0, 1'b1, 1'b0));
    send_pixel(make_pixel(0, 0, 0, 1'b0, 1'b1));
    send_pixel(make_pixel(0, 255, 0, 1'b1, 1'b0));
    send_pixel(make_pixel(255, 255, 0, 1'b1, 1'b0));
  endtask

  task automatic test_random_images();
    int target;
    int r;
    int len;
    logic [CFG_DATA_BITS-1:0] margin_word;
    logic [CFG_DATA_BITS-1:0] scale_word;
    target = items_sent + RANDOM_PIXELS;
    while (items_sent < target) begin
      margin_word = CFG_DATA_BITS'($urandom_range(0, 1023));
      r = $urandom_range(0, 3);
      if (r == 0) margin_word[7:0] = 8'd0;
      else if (r == 1) margin_word[7:0] = 8'd255;
      else if (r == 2) margin_word[7:0] = 8'($urandom_range(0, 40));
      r = $urandom_range(0, 3);
      scale_word = (r == 0) ? 10'd1 : (r == 1) ? 10'd1023 : 10'($urandom_range(1, 1023));
      configure(margin_word, scale_word);
      repeat ($urandom_range(4, 10)) begin
        r = $urandom_range(0, 99);
        len = (r < 70) ? $urandom_range(1, 6) : (r < 95) ? $urandom_range(7, 30)
                                                       : $urandom_range(31, 200);
        send_image(len, $urandom_range(0, NOISE));
      end
    end
  endtask

  // Hold the result side so the image queue fills and pixel ready drops
  task automatic test_result_hold_off();
    configure(10'd60, 10'd1000);
    no_idle  = 1'b1;
    hold_off = 400;
    for (int n = 0; n < 24; n++) send_image($urandom_range(1, 2), n % (NOISE + 1));
    no_idle = 1'b0;
  endtask

  task automatic test_steady_stream();
    configure(10'd30, 10'd512);
    no_idle = 1'b1;
    repeat (12) send_image($urandom_range(1, 6), $urandom_range(0, NOISE));
    no_idle = 1'b0;
  endtask

  initial begin
    rst                     <= 1'b1;
    pixel_bus.valid         <= 1'b0;
    pixel_bus.red           <= '0;
    pixel_bus.green         <= '0;
    pixel_bus.blue          <= '0;
    pixel_bus.last_of_image <= 1'b0;
    pixel_bus.new_bank      <= 1'b0;
    cfg_bus.valid           <= 1'b0;
    cfg_bus.index           <= REG_MARGIN;
    cfg_bus.data            <= '0;
    margin_q     = MARGIN_RESET;
    scale_q      = SCALE_RESET;
    image_pixels = '0;
    foreach (class_pixels[k]) class_pixels[k] = '0;
    foreach (image_tally[k]) image_tally[k] = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_margin_zero();
    test_scale_extremes();
    test_random_images();
    test_result_hold_off();
    test_steady_stream();
    wait_idle();

    $display("Sent %0d pixels in %0d images, checked %0d results, %0d mismatches.",
             items_sent, images_sent, results_seen, mismatches);
    $display("Margins 0..255, scales 0..1023, bank clears, ties and a long result hold-off.");
    if (mismatches == 0)
      $display("** dominant_color_classifier: PASSED **");
    else
      $display("** dominant_color_classifier: FAILED **");
    $finish;
  end

endmodule
